// ===== src/minimum_spanning_tree_top_macros.svh =====
// assertion macros shared by the minimum spanning tree block
// depends on nothing; included by mst_back, the module that carries checks
`ifndef MINIMUM_SPANNING_TREE_TOP_MACROS_SVH
`define MINIMUM_SPANNING_TREE_TOP_MACROS_SVH

// check that is off while reset is high
`define MST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds during reset
`define MST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mst_pkg.sv =====
// types, sizes and state codes of the minimum spanning tree block
// depends on nothing; used by every module of the block
package mst_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int MAX_EDGES    = 256;

   localparam int VERT_W       = $clog2(MAX_VERTICES);
   localparam int EDGE_IDX_W   = $clog2(MAX_EDGES);
   localparam int EDGE_CNT_W   = $clog2(MAX_EDGES + 1);
   localparam int WEIGHT_W     = 16;
   localparam int TOTAL_W      = 21;
   localparam int RANK_W       = 3;
   localparam int KEY_W        = WEIGHT_W + 2 * VERT_W;
   localparam int MAX_TREE     = MAX_VERTICES - 1;
   localparam int TREE_CNT_W   = $clog2(MAX_VERTICES);

   // sort key fields: biased weight, source, destination
   localparam int KEY_TO_LSB   = 0;
   localparam int KEY_FROM_LSB = VERT_W;
   localparam int KEY_W_LSB    = 2 * VERT_W;

   localparam int QUEUE_DEPTH  = 4;
   localparam int Q_IDX_W      = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             last;
   } queue_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_PICK,
      ST_FIND,
      ST_COMPRESS,
      ST_CHECK,
      ST_EMIT,
      ST_RANK_A,
      ST_RANK_B,
      ST_TOTAL
   } back_state_type;

endpackage

// ===== src/mst_front.sv =====
// front end: takes edge transactions, packs the sort key, queues them
// depends on mst_pkg
module mst_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mst_pkg::VERT_W-1:0]            req_from_vertex,
   input  logic [mst_pkg::VERT_W-1:0]            req_to_vertex,
   input  logic signed [mst_pkg::WEIGHT_W-1:0]   req_edge_weight,
   input  logic                                  req_last_edge,
   output logic                                  q_valid,
   input  logic                                  q_ready,
   output mst_pkg::queue_entry_type              q_entry
);

   mst_pkg::queue_entry_type           mem_ff [mst_pkg::QUEUE_DEPTH];
   logic [mst_pkg::Q_IDX_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mst_pkg::Q_IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mst_pkg::Q_CNT_W-1:0]        fill_ff, fill_in;
   mst_pkg::queue_entry_type           new_entry;
   logic                               push, pop;

   // key: weight with sign bit flipped, then source, then destination
   always_comb begin
      new_entry.key  = {~req_edge_weight[mst_pkg::WEIGHT_W-1],
                        req_edge_weight[mst_pkg::WEIGHT_W-2:0],
                        req_from_vertex, req_to_vertex};
      new_entry.last = req_last_edge;
   end

   assign req_ready = (fill_ff != mst_pkg::Q_CNT_W'(mst_pkg::QUEUE_DEPTH));
   assign q_valid   = (fill_ff != '0);
   assign q_entry   = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== src/mst_back.sv =====
// back end: edge store, repeated minimum scan, union-find walks, results
// depends on mst_pkg and minimum_spanning_tree_top_macros.svh
`include "minimum_spanning_tree_top_macros.svh"
module mst_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   output logic                                  q_ready,
   input  mst_pkg::queue_entry_type              q_entry,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_is_total,
   output logic [mst_pkg::VERT_W-1:0]            rsp_tree_from,
   output logic [mst_pkg::VERT_W-1:0]            rsp_tree_to,
   output logic signed [mst_pkg::TOTAL_W-1:0]    rsp_total_weight,
   output logic                                  rsp_edges_dropped,
   output logic                                  rsp_last_result
);

   localparam int VW = mst_pkg::VERT_W;
   localparam int KW = mst_pkg::KEY_W;

   mst_pkg::back_state_type          state_ff, state_in;
   logic [mst_pkg::EDGE_CNT_W-1:0]   count_ff, count_in;
   logic                             overflow_ff, overflow_in;
   logic [KW-1:0]                    store_mem [mst_pkg::MAX_EDGES];
   logic [KW-1:0]                    rd_data_ff;
   logic                             store_we;

   logic [mst_pkg::EDGE_CNT_W-1:0]   scan_addr_ff, scan_addr_in;
   logic                             rd_pend_ff, rd_pend_in;
   logic [KW-1:0]                    best_ff, best_in;
   logic                             found_ff, found_in;
   logic [KW-1:0]                    prev_ff, prev_in;
   logic                             have_prev_ff, have_prev_in;
   logic [mst_pkg::TREE_CNT_W-1:0]   tree_cnt_ff, tree_cnt_in;
   logic signed [mst_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic [VW-1:0]                    parent_ff [mst_pkg::MAX_VERTICES];
   logic [mst_pkg::RANK_W-1:0]       rank_ff [mst_pkg::MAX_VERTICES];
   logic [VW-1:0]                    cur_ff, cur_in;
   logic [VW-1:0]                    start_ff, start_in;
   logic [VW-1:0]                    root_ff, root_in;
   logic [VW-1:0]                    root_u_ff, root_u_in;
   logic                             phase_ff, phase_in;
   logic [mst_pkg::RANK_W-1:0]       rank_a_ff, rank_a_in;

   logic [VW-1:0]                    uf_idx;
   logic [VW-1:0]                    parent_rd;
   logic [mst_pkg::RANK_W-1:0]       rank_rd;
   logic                             par_we, rank_we, sets_clear;
   logic [VW-1:0]                    par_waddr, par_wdata, rank_waddr;
   logic [mst_pkg::RANK_W-1:0]       rank_wdata;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_is_total_ff, rsp_is_total_in;
   logic [VW-1:0]                    rsp_from_ff, rsp_from_in;
   logic [VW-1:0]                    rsp_to_ff, rsp_to_in;
   logic signed [mst_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                             rsp_dropped_ff, rsp_dropped_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             out_free;
   logic [mst_pkg::WEIGHT_W-1:0]     best_w;
   logic signed [mst_pkg::TOTAL_W-1:0] best_w_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_ready   = (state_ff == mst_pkg::ST_IDLE);
   assign parent_rd = parent_ff[uf_idx];
   assign rank_rd   = rank_ff[uf_idx];

   // weight of the picked edge, bias removed and sign extended
   assign best_w     = {~best_ff[KW-1], best_ff[KW-2:mst_pkg::KEY_W_LSB]};
   assign best_w_ext = {{(mst_pkg::TOTAL_W - mst_pkg::WEIGHT_W){best_w[mst_pkg::WEIGHT_W-1]}},
                        best_w};

   // shared union-find read index
   always_comb begin
      case (state_ff)
         mst_pkg::ST_RANK_A: uf_idx = root_u_ff;
         mst_pkg::ST_RANK_B: uf_idx = root_ff;
         default:            uf_idx = cur_ff;
      endcase
   end

   // next state and datapath control
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      overflow_in     = overflow_ff;
      store_we        = 1'b0;
      scan_addr_in    = scan_addr_ff;
      rd_pend_in      = 1'b0;
      best_in         = best_ff;
      found_in        = found_ff;
      prev_in         = prev_ff;
      have_prev_in    = have_prev_ff;
      tree_cnt_in     = tree_cnt_ff;
      total_in        = total_ff;
      cur_in          = cur_ff;
      start_in        = start_ff;
      root_in         = root_ff;
      root_u_in       = root_u_ff;
      phase_in        = phase_ff;
      rank_a_in       = rank_a_ff;
      par_we          = 1'b0;
      par_waddr       = cur_ff;
      par_wdata       = root_ff;
      rank_we         = 1'b0;
      rank_waddr      = root_ff;
      rank_wdata      = rank_rd + 1'b1;
      sets_clear      = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_is_total_in = rsp_is_total_ff;
      rsp_from_in     = rsp_from_ff;
      rsp_to_in       = rsp_to_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      rsp_last_in     = rsp_last_ff;

      case (state_ff)
         // load edges until the last mark
         mst_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (count_ff < mst_pkg::EDGE_CNT_W'(mst_pkg::MAX_EDGES)) begin
                  store_we = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               if (q_entry.last) begin
                  state_in = mst_pkg::ST_INIT;
               end
            end
         end
         // singleton sets and a fresh run
         mst_pkg::ST_INIT: begin
            sets_clear   = 1'b1;
            total_in     = '0;
            tree_cnt_in  = '0;
            have_prev_in = 1'b0;
            scan_addr_in = '0;
            found_in     = 1'b0;
            state_in     = mst_pkg::ST_SCAN;
         end
         // one pass: smallest key above the previous one
         mst_pkg::ST_SCAN: begin
            if (scan_addr_ff < count_ff) begin
               scan_addr_in = scan_addr_ff + 1'b1;
               rd_pend_in   = 1'b1;
            end
            if (rd_pend_ff) begin
               if ((!have_prev_ff || rd_data_ff > prev_ff) &&
                   (!found_ff || rd_data_ff < best_ff)) begin
                  best_in  = rd_data_ff;
                  found_in = 1'b1;
               end
            end else if (scan_addr_ff == count_ff) begin
               state_in = mst_pkg::ST_PICK;
            end
         end
         mst_pkg::ST_PICK: begin
            if (!found_ff || tree_cnt_ff == mst_pkg::TREE_CNT_W'(mst_pkg::MAX_TREE)) begin
               state_in = mst_pkg::ST_TOTAL;
            end else begin
               prev_in      = best_ff;
               have_prev_in = 1'b1;
               cur_in       = best_ff[mst_pkg::KEY_FROM_LSB +: VW];
               start_in     = best_ff[mst_pkg::KEY_FROM_LSB +: VW];
               phase_in     = 1'b0;
               state_in     = mst_pkg::ST_FIND;
            end
         end
         // walk to the root
         mst_pkg::ST_FIND: begin
            if (parent_rd == cur_ff) begin
               root_in  = cur_ff;
               cur_in   = start_ff;
               state_in = mst_pkg::ST_COMPRESS;
            end else begin
               cur_in = parent_rd;
            end
         end
         // path compression, second walk
         mst_pkg::ST_COMPRESS: begin
            if (cur_ff == root_ff) begin
               if (!phase_ff) begin
                  root_u_in = root_ff;
                  cur_in    = best_ff[mst_pkg::KEY_TO_LSB +: VW];
                  start_in  = best_ff[mst_pkg::KEY_TO_LSB +: VW];
                  phase_in  = 1'b1;
                  state_in  = mst_pkg::ST_FIND;
               end else begin
                  state_in = mst_pkg::ST_CHECK;
               end
            end else begin
               par_we = 1'b1;
               cur_in = parent_rd;
            end
         end
         mst_pkg::ST_CHECK: begin
            scan_addr_in = '0;
            found_in     = 1'b0;
            state_in     = (root_u_ff != root_ff) ? mst_pkg::ST_EMIT : mst_pkg::ST_SCAN;
         end
         // tree edge transaction
         mst_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_total_in = 1'b0;
               rsp_from_in     = best_ff[mst_pkg::KEY_FROM_LSB +: VW];
               rsp_to_in       = best_ff[mst_pkg::KEY_TO_LSB +: VW];
               rsp_total_in    = '0;
               rsp_dropped_in  = 1'b0;
               rsp_last_in     = 1'b0;
               total_in        = total_ff + best_w_ext;
               tree_cnt_in     = tree_cnt_ff + 1'b1;
               state_in        = mst_pkg::ST_RANK_A;
            end
         end
         mst_pkg::ST_RANK_A: begin
            rank_a_in = rank_rd;
            state_in  = mst_pkg::ST_RANK_B;
         end
         // union by rank
         mst_pkg::ST_RANK_B: begin
            par_we = 1'b1;
            if (rank_a_ff > rank_rd) begin
               par_waddr = root_ff;
               par_wdata = root_u_ff;
            end else begin
               par_waddr = root_u_ff;
               par_wdata = root_ff;
               rank_we   = (rank_a_ff == rank_rd);
            end
            state_in = mst_pkg::ST_SCAN;
         end
         // total transaction, then back to loading
         mst_pkg::ST_TOTAL: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_total_in = 1'b1;
               rsp_from_in     = '0;
               rsp_to_in       = '0;
               rsp_total_in    = total_ff;
               rsp_dropped_in  = overflow_ff;
               rsp_last_in     = 1'b1;
               count_in        = '0;
               overflow_in     = 1'b0;
               total_in        = '0;
               tree_cnt_in     = '0;
               state_in        = mst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mst_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mst_pkg::ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
         tree_cnt_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
         have_prev_ff <= have_prev_in;
         tree_cnt_ff  <= tree_cnt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_addr_ff    <= scan_addr_in;
      best_ff         <= best_in;
      prev_ff         <= prev_in;
      cur_ff          <= cur_in;
      start_ff        <= start_in;
      root_ff         <= root_in;
      root_u_ff       <= root_u_in;
      phase_ff        <= phase_in;
      rank_a_ff       <= rank_a_in;
      rsp_is_total_ff <= rsp_is_total_in;
      rsp_from_ff     <= rsp_from_in;
      rsp_to_ff       <= rsp_to_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_dropped_ff  <= rsp_dropped_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // edge store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[mst_pkg::EDGE_IDX_W-1:0]] <= q_entry.key;
      end
      rd_data_ff <= store_mem[scan_addr_ff[mst_pkg::EDGE_IDX_W-1:0]];
   end

   // parent and rank registers
   always_ff @(posedge clock) begin
      if (reset || sets_clear) begin
         for (int i = 0; i < mst_pkg::MAX_VERTICES; i++) begin
            parent_ff[i] <= VW'(i);
            rank_ff[i]   <= '0;
         end
      end else begin
         if (par_we) begin
            parent_ff[par_waddr] <= par_wdata;
         end
         if (rank_we) begin
            rank_ff[rank_waddr] <= rank_wdata;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_total      = rsp_is_total_ff;
   assign rsp_tree_from     = rsp_from_ff;
   assign rsp_tree_to       = rsp_to_ff;
   assign rsp_total_weight  = rsp_total_ff;
   assign rsp_edges_dropped = rsp_dropped_ff;
   assign rsp_last_result   = rsp_last_ff;

   // checks
   `MST_ASSERT(a_count_bound, clock, reset, count_ff <= mst_pkg::EDGE_CNT_W'(mst_pkg::MAX_EDGES), "edge count beyond store")
   `MST_ASSERT(a_tree_bound, clock, reset, tree_cnt_ff <= mst_pkg::TREE_CNT_W'(mst_pkg::MAX_TREE), "too many tree edges")
   `MST_ASSERT(a_run_end, clock, reset, (state_ff == mst_pkg::ST_TOTAL && out_free) |=> (count_ff == '0 && !overflow_ff && state_ff == mst_pkg::ST_IDLE), "run state not cleared after total")

endmodule

// ===== src/minimum_spanning_tree_top.sv =====
// Minimum spanning tree by Kruskal's method. Edge transactions load at one per
// cycle while the back end is idle, through a four-entry queue into a 256-entry
// edge store; extra edges are dropped and reported on the total. The edge marked
// last starts a run: the init state clears the union-find sets, then the stored
// keys are taken one at a time in weight, source, destination order, each found
// by a full pass over the store (one store read port). Each key then goes through
// the pick state, the two root walks with path compression and the check state;
// a tree edge adds the output state and the union by rank states.
// A run stops once 31 tree edges are found or no key is left, and it ends with
// one more pass over the store and then the total transaction.
// Tree edges come out in order, then one total transaction with last_result set.
// No new edge is taken from the queue until the total has been issued.
// depends on mst_pkg, mst_front and mst_back
module minimum_spanning_tree_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mst_pkg::VERT_W-1:0]            req_from_vertex,
   input  logic [mst_pkg::VERT_W-1:0]            req_to_vertex,
   input  logic signed [mst_pkg::WEIGHT_W-1:0]   req_edge_weight,
   input  logic                                  req_last_edge,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_is_total,
   output logic [mst_pkg::VERT_W-1:0]            rsp_tree_from,
   output logic [mst_pkg::VERT_W-1:0]            rsp_tree_to,
   output logic signed [mst_pkg::TOTAL_W-1:0]    rsp_total_weight,
   output logic                                  rsp_edges_dropped,
   output logic                                  rsp_last_result
);

   logic                      q_valid;
   logic                      q_ready;
   mst_pkg::queue_entry_type  q_entry;

   // intake and queue
   mst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .req_edge_weight (req_edge_weight),
      .req_last_edge   (req_last_edge),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_entry         (q_entry)
   );

   // store, sort scan and union-find
   mst_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_entry           (q_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_total      (rsp_is_total),
      .rsp_tree_from     (rsp_tree_from),
      .rsp_tree_to       (rsp_tree_to),
      .rsp_total_weight  (rsp_total_weight),
      .rsp_edges_dropped (rsp_edges_dropped),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

// ===== dv/mst_checker.sv =====
// checker for the minimum spanning tree block: watches both channels, predicts
// the tree edges and total of each graph, and counts mismatches
// depends on mst_pkg
module mst_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [mst_pkg::VERT_W-1:0]          req_from_vertex,
   input  logic [mst_pkg::VERT_W-1:0]          req_to_vertex,
   input  logic signed [mst_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic                                req_last_edge,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_is_total,
   input  logic [mst_pkg::VERT_W-1:0]          rsp_tree_from,
   input  logic [mst_pkg::VERT_W-1:0]          rsp_tree_to,
   input  logic signed [mst_pkg::TOTAL_W-1:0]  rsp_total_weight,
   input  logic                                rsp_edges_dropped,
   input  logic                                rsp_last_result,
   output int                                  fail_count,
   output int                                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                                is_total;
      logic [mst_pkg::VERT_W-1:0]          tree_from;
      logic [mst_pkg::VERT_W-1:0]          tree_to;
      logic signed [mst_pkg::TOTAL_W-1:0]  total_weight;
      logic                                edges_dropped;
      logic                                last_result;
   } mst_result_type;

   mst_result_type               tree_results_q[$];
   logic [mst_pkg::KEY_W-1:0]    graph_keys[$];
   logic                         graph_overflow;
   logic [mst_pkg::VERT_W-1:0]   parent_of[mst_pkg::MAX_VERTICES];
   logic [mst_pkg::RANK_W-1:0]   rank_of[mst_pkg::MAX_VERTICES];

   assign pending_count = tree_results_q.size();

   // root walk with path compression
   function automatic logic [mst_pkg::VERT_W-1:0] find_root(
         logic [mst_pkg::VERT_W-1:0] v);
      logic [mst_pkg::VERT_W-1:0] r;
      logic [mst_pkg::VERT_W-1:0] nx;
      r = v;
      while (parent_of[r] != r) r = parent_of[r];
      while (v != r) begin
         nx = parent_of[v];
         parent_of[v] = r;
         v = nx;
      end
      return r;
   endfunction

   // sort the graph and run kruskal, queueing the expected transactions
   task automatic solve_graph();
      logic [mst_pkg::KEY_W-1:0]          keys[$];
      logic [mst_pkg::VERT_W-1:0]         u, v, ru, rv;
      logic signed [mst_pkg::TOTAL_W-1:0] sum;
      mst_result_type                     res;
      int                                 found;
      keys = graph_keys;
      keys.sort();
      for (int i = 0; i < mst_pkg::MAX_VERTICES; i++) begin
         parent_of[i] = mst_pkg::VERT_W'(i);
         rank_of[i] = '0;
      end
      sum = '0;
      found = 0;
      foreach (keys[i]) begin
         if (found >= mst_pkg::MAX_TREE) break;
         u = keys[i][mst_pkg::KEY_FROM_LSB +: mst_pkg::VERT_W];
         v = keys[i][mst_pkg::KEY_TO_LSB +: mst_pkg::VERT_W];
         ru = find_root(u);
         rv = find_root(v);
         if (ru != rv) begin
            res = '0;
            res.tree_from = u;
            res.tree_to = v;
            tree_results_q.insert(tree_results_q.size(), res);
            sum += mst_pkg::TOTAL_W'(signed'({1'b0,
                      keys[i][mst_pkg::KEY_W_LSB +: mst_pkg::WEIGHT_W]}) - 32768);
            if (rank_of[ru] > rank_of[rv]) parent_of[rv] = ru;
            else begin
               parent_of[ru] = rv;
               if (rank_of[ru] == rank_of[rv]) rank_of[rv] = rank_of[rv] + 1'b1;
            end
            found++;
         end
      end
      res = '0;
      res.is_total = 1'b1;
      res.total_weight = sum;
      res.edges_dropped = graph_overflow;
      res.last_result = 1'b1;
      tree_results_q.insert(tree_results_q.size(), res);
      graph_keys.delete();
      graph_overflow = 1'b0;
   endtask

   // field by field comparison against the oldest expectation
   task automatic check_result();
      mst_result_type exp_r;
      if (tree_results_q.size() == 0) begin
         $error("unexpected result transaction");
         fail_count++;
         return;
      end
      exp_r = tree_results_q.pop_front();
      if (rsp_is_total !== exp_r.is_total) begin
         $error("is_total exp %0d got %0d", exp_r.is_total, rsp_is_total); fail_count++;
      end
      if (rsp_tree_from !== exp_r.tree_from) begin
         $error("tree_from exp %0d got %0d", exp_r.tree_from, rsp_tree_from); fail_count++;
      end
      if (rsp_tree_to !== exp_r.tree_to) begin
         $error("tree_to exp %0d got %0d", exp_r.tree_to, rsp_tree_to); fail_count++;
      end
      if (rsp_total_weight !== exp_r.total_weight) begin
         $error("total_weight exp %0d got %0d", exp_r.total_weight, rsp_total_weight);
         fail_count++;
      end
      if (rsp_edges_dropped !== exp_r.edges_dropped) begin
         $error("edges_dropped exp %0d got %0d", exp_r.edges_dropped, rsp_edges_dropped);
         fail_count++;
      end
      if (rsp_last_result !== exp_r.last_result) begin
         $error("last_result exp %0d got %0d", exp_r.last_result, rsp_last_result);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      graph_overflow = 1'b0;
   end

   // request transactions feed the prediction, responses are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) begin
            if (graph_keys.size() < mst_pkg::MAX_EDGES)
               graph_keys.insert(graph_keys.size(),
                                 {req_edge_weight ^ 16'h8000, req_from_vertex,
                                  req_to_vertex});
            else graph_overflow = 1'b1;
            if (req_last_edge) solve_graph();
         end
      end
   end
endmodule

// ===== dv/minimum_spanning_tree_top_tb.sv =====
// top of the minimum spanning tree testbench: clock, reset, edge stimulus and
// verdict; depends on mst_pkg, mst_checker and minimum_spanning_tree_top
module minimum_spanning_tree_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [mst_pkg::VERT_W-1:0] req_from_vertex = '0, req_to_vertex = '0;
   logic signed [mst_pkg::WEIGHT_W-1:0] req_edge_weight = '0;
   logic req_last_edge = 1'b0;
   logic rsp_valid, rsp_ready = 1'b0, rsp_is_total, rsp_edges_dropped, rsp_last_result;
   logic [mst_pkg::VERT_W-1:0] rsp_tree_from, rsp_tree_to;
   logic signed [mst_pkg::TOTAL_W-1:0] rsp_total_weight;
   int fail_count, pending_count;
   int cycle_count = 0;
   bit calm_phase = 1'b0;

   always #5 clock = ~clock;

   minimum_spanning_tree_top u_dut (.*);

   mst_checker u_checker (.*);

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // random receiver stalls
   always @(posedge clock)
      rsp_ready <= calm_phase || ($urandom_range(99) >= 22);

   // one edge transaction, with random idle gaps before it
   task automatic send_edge(input logic [4:0] f, input logic [4:0] t,
                            input logic [15:0] w, input logic lst);
      while (!calm_phase && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_from_vertex <= f;
      req_to_vertex <= t;
      req_edge_weight <= w;
      req_last_edge <= lst;
      do @(posedge clock); while (!req_ready);
   endtask

   // random graph: vertex span drawn from 2 to 31, so narrow spans close many cycles
   task automatic send_graph(input int n_edges);
      int span;
      span = $urandom_range(31, 2);
      for (int i = 0; i < n_edges; i++)
         send_edge(5'($urandom_range(span)), 5'($urandom_range(span)),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
                   i == n_edges - 1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty-ish graph, extremes of weight, self loop, ties
      send_edge(5'd3, 5'd3, 16'sh7fff, 1'b1);
      send_edge(5'd0, 5'd31, 16'sh8000, 1'b0);
      send_edge(5'd31, 5'd0, 16'sh7fff, 1'b0);
      send_edge(5'd1, 5'd2, 16'sh0000, 1'b0);
      send_edge(5'd2, 5'd1, 16'sh0000, 1'b0);
      send_edge(5'd1, 5'd1, 16'sh8000, 1'b0);
      send_edge(5'd0, 5'd2, 16'shffff, 1'b1);
      // chain over all 32 vertices, max tree size and extreme sum
      for (int i = 0; i < 31; i++)
         send_edge(5'(i), 5'(i + 1), 16'sh8000, 1'b0);
      send_edge(5'd31, 5'd0, 16'sh8000, 1'b1);
      // a longer graph with no idling on either side
      calm_phase = 1'b1;
      send_graph(30);
      calm_phase = 1'b0;
      // random graphs
      for (int g = 0; g < 12; g++) send_graph($urandom_range(14, 1));
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
